/* sv/scjr_pkg.sv */
// Shared types, result codes and command/reply byte tables for the serial
// JPEG camera reader. No dependencies; all files but scjr_ifs use it by scope.
package scjr_pkg;

    localparam int CHUNK_BYTES_DEF = 32;
    localparam int QUEUE_DEPTH     = 4;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_CAP_FAIL  = 3'd1;
    localparam logic [2:0] ST_SIZE_OK   = 3'd2;
    localparam logic [2:0] ST_SIZE_BAD  = 3'd3;
    localparam logic [2:0] ST_FRAME_BAD = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;

    // command bursts
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_TAKE  = 2'd1;
    localparam logic [1:0] CMD_SIZE  = 2'd2;
    localparam logic [1:0] CMD_CHUNK = 2'd3;

    localparam logic [4:0] SHORT_CMD_LEN = 5'd5;
    localparam logic [4:0] CHUNK_CMD_LEN = 5'd16;

    localparam logic [7:0] MARK_HI = 8'hFF;
    localparam logic [7:0] MARK_LO = 8'hD9;

    // one unit of work handed from the front to the back
    typedef struct packed {
        logic [2:0]  st_a;
        logic [2:0]  st_b;
        logic        data_en;
        logic [7:0]  data;
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [15:0] size;
        logic [15:0] count;
    } job_t;

    function automatic logic [7:0] take_cmd_byte(input logic [2:0] i);
        logic [7:0] b;
        b = 8'h00;
        case (i)
            3'd0:    b = 8'h56;
            3'd2:    b = 8'h36;
            3'd3:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] size_cmd_byte(input logic [2:0] i);
        logic [7:0] b;
        b = 8'h00;
        case (i)
            3'd0:    b = 8'h56;
            3'd2:    b = 8'h34;
            3'd3:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] take_ack_byte(input logic [2:0] i);
        logic [7:0] b;
        b = 8'h00;
        case (i)
            3'd0:    b = 8'h76;
            3'd2:    b = 8'h36;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] size_ack_byte(input logic [2:0] i);
        logic [7:0] b;
        b = 8'h00;
        case (i)
            3'd0:    b = 8'h76;
            3'd2:    b = 8'h34;
            3'd4:    b = 8'h04;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] frame_byte(input logic [2:0] i);
        logic [7:0] b;
        b = 8'h00;
        case (i)
            3'd0:    b = 8'h76;
            3'd2:    b = 8'h32;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] chunk_cmd_byte(input logic [3:0] i,
                                                  input logic [15:0] addr,
                                                  input logic [7:0] chunk);
        logic [7:0] b;
        b = 8'h00;
        case (i)
            4'd0:    b = 8'h56;
            4'd2:    b = 8'h32;
            4'd3:    b = 8'h0C;
            4'd5:    b = 8'h0A;
            4'd8:    b = addr[15:8];
            4'd9:    b = addr[7:0];
            4'd13:   b = chunk;
            4'd15:   b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* sv/scjr_ifs.sv */
// Handshake interfaces for the request and result channels.
// Depends on nothing.
interface scjr_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface scjr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  byte_value;
    logic [2:0]  status_code;
    logic [15:0] image_size;
    logic [15:0] byte_count;
    logic        last_of_run;

    modport source (output valid, output result_kind, output byte_value,
                    output status_code, output image_size, output byte_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input byte_value,
                    input status_code, input image_size, input byte_count,
                    input last_of_run, output ready);
endinterface

/* sv/scjr_front.sv */
// Front part: accepts request words, runs the exchange state machine and
// queues one job per word that causes results. Depends on scjr_pkg, scjr_ifs.
module scjr_front #(
    parameter int CHUNK_BYTES = scjr_pkg::CHUNK_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    scjr_req_if.sink           req,
    input  logic               full,
    output logic               push,
    output scjr_pkg::job_t     push_job
);

    localparam logic [7:0]  CHUNK_B = 8'(CHUNK_BYTES);
    localparam logic [15:0] ADDR_STEP = 16'(CHUNK_BYTES);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_CAP  = 3'd1;
    localparam logic [2:0] PH_SIZE = 3'd2;
    localparam logic [2:0] PH_HDR  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_FTR  = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  idx_reg, idx_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  prev_reg, prev_next;
    logic        good_reg, good_next;
    logic        end_reg, end_next;

    logic           accept;
    logic [7:0]     b;
    logic [7:0]     idx_inc;
    scjr_pkg::job_t job;

    assign req.ready = !full;
    assign accept    = req.valid && req.ready;
    assign b         = req.rx_byte;
    assign idx_inc   = idx_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        addr_next  = addr_reg;
        size_next  = size_reg;
        count_next = count_reg;
        prev_next  = prev_reg;
        good_next  = good_reg;
        end_next   = end_reg;
        job        = '0;
        if (!req.req_type)
        begin
            phase_next = PH_CAP;
            idx_next   = 8'd0;
            addr_next  = 16'd0;
            size_next  = 16'd0;
            count_next = 16'd0;
            prev_next  = 8'd0;
            good_next  = 1'b1;
            end_next   = 1'b0;
            job.cmd    = scjr_pkg::CMD_TAKE;
        end
        else
        begin
            unique case (phase_reg)
                PH_CAP:
                begin
                    good_next = good_reg && (b == scjr_pkg::take_ack_byte(idx_reg[2:0]));
                    idx_next  = idx_inc;
                    if (idx_inc >= 8'd5)
                    begin
                        if (good_next)
                        begin
                            job.cmd    = scjr_pkg::CMD_SIZE;
                            phase_next = PH_SIZE;
                            idx_next   = 8'd0;
                            good_next  = 1'b1;
                        end
                        else
                        begin
                            job.st_a   = scjr_pkg::ST_CAP_FAIL;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_SIZE:
                begin
                    if (idx_reg < 8'd7)
                    begin
                        good_next = good_reg &&
                                    (b == scjr_pkg::size_ack_byte(idx_reg[2:0]));
                    end
                    else if (idx_reg == 8'd7)
                    begin
                        size_next = {b, size_reg[7:0]};
                    end
                    else
                    begin
                        size_next = {size_reg[15:8], b};
                    end
                    idx_next = idx_inc;
                    if (idx_inc >= 8'd9)
                    begin
                        if (good_next)
                        begin
                            job.st_a = scjr_pkg::ST_SIZE_OK;
                        end
                        else
                        begin
                            size_next = 16'd0;
                            job.st_a  = scjr_pkg::ST_SIZE_BAD;
                        end
                        job.cmd    = scjr_pkg::CMD_CHUNK;
                        phase_next = PH_HDR;
                        idx_next   = 8'd0;
                        good_next  = 1'b1;
                    end
                end
                PH_HDR:
                begin
                    good_next = good_reg && (b == scjr_pkg::frame_byte(idx_reg[2:0]));
                    idx_next  = idx_inc;
                    if (idx_inc >= 8'd5)
                    begin
                        if (good_next)
                        begin
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            // skip the data bytes, take what follows as footer
                            job.st_a   = scjr_pkg::ST_FRAME_BAD;
                            prev_next  = 8'd0;
                            phase_next = PH_FTR;
                        end
                        idx_next  = 8'd0;
                        good_next = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    if (!end_reg)
                    begin
                        count_next  = count_reg + 16'd1;
                        job.data_en = 1'b1;
                        job.data    = b;
                        if (prev_reg == scjr_pkg::MARK_HI && b == scjr_pkg::MARK_LO)
                        begin
                            end_next = 1'b1;
                        end
                        prev_next = b;
                    end
                    idx_next = idx_inc;
                    if (idx_inc >= CHUNK_B)
                    begin
                        phase_next = PH_FTR;
                        idx_next   = 8'd0;
                        good_next  = 1'b1;
                    end
                end
                PH_FTR:
                begin
                    good_next = good_reg && (b == scjr_pkg::frame_byte(idx_reg[2:0]));
                    idx_next  = idx_inc;
                    if (idx_inc >= 8'd5)
                    begin
                        if (!good_next)
                        begin
                            job.st_a = scjr_pkg::ST_FRAME_BAD;
                        end
                        addr_next = addr_reg + ADDR_STEP;
                        if (end_reg)
                        begin
                            job.st_b   = scjr_pkg::ST_DONE;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            job.cmd    = scjr_pkg::CMD_CHUNK;
                            phase_next = PH_HDR;
                            idx_next   = 8'd0;
                            good_next  = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // idle or unused code: drop the byte
                    phase_next = PH_IDLE;
                end
            endcase
        end
        job.addr  = addr_next;
        job.size  = size_next;
        job.count = count_next;
    end

    assign push_job = job;
    assign push     = accept && ((job.st_a != scjr_pkg::ST_NONE) ||
                                 (job.st_b != scjr_pkg::ST_NONE) ||
                                 job.data_en || (job.cmd != scjr_pkg::CMD_NONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= 8'd0;
            addr_reg  <= 16'd0;
            size_reg  <= 16'd0;
            count_reg <= 16'd0;
            prev_reg  <= 8'd0;
            good_reg  <= 1'b1;
            end_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            addr_reg  <= addr_next;
            size_reg  <= size_next;
            count_reg <= count_next;
            prev_reg  <= prev_next;
            good_reg  <= good_next;
            end_reg   <= end_next;
        end
    end

endmodule

/* sv/scjr_queue.sv */
// Short job queue between the front and the back.
// Depends on scjr_pkg.
module scjr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scjr_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output scjr_pkg::job_t  head_job,
    output logic            empty
);

    localparam int DEPTH = scjr_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    scjr_pkg::job_t      slots_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg;
    logic [PW-1:0]       rd_ptr_reg;
    logic [PW:0]         fill_reg;
    logic                do_push;
    logic                do_pop;

    assign full     = (fill_reg == (PW+1)'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + (PW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - (PW+1)'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed into a full queue");
`endif

endmodule

/* sv/scjr_back.sv */
// Back part: expands each queued job into result words, one per cycle while
// the result port is ready: leading status, second status, image byte, then
// command bytes. Depends on scjr_pkg, scjr_ifs.
module scjr_back #(
    parameter int CHUNK_BYTES = scjr_pkg::CHUNK_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  scjr_pkg::job_t  head_job,
    output logic            pop,
    scjr_res_if.source      res
);

    localparam logic [7:0] CHUNK_B = 8'(CHUNK_BYTES);

    scjr_pkg::job_t cur_reg;
    logic           busy_reg;
    logic [3:0]     cidx_reg;

    logic [4:0]     cmd_len;
    logic [4:0]     cidx_inc;
    logic           more;
    logic           fire;
    logic [7:0]     cmd_byte;

    always_comb
    begin
        unique case (cur_reg.cmd)
            scjr_pkg::CMD_TAKE:  cmd_byte = scjr_pkg::take_cmd_byte(cidx_reg[2:0]);
            scjr_pkg::CMD_SIZE:  cmd_byte = scjr_pkg::size_cmd_byte(cidx_reg[2:0]);
            scjr_pkg::CMD_CHUNK: cmd_byte = scjr_pkg::chunk_cmd_byte(cidx_reg,
                                                                     cur_reg.addr, CHUNK_B);
            default:             cmd_byte = 8'h00;
        endcase
        cmd_len = (cur_reg.cmd == scjr_pkg::CMD_CHUNK) ? scjr_pkg::CHUNK_CMD_LEN
                                                       : scjr_pkg::SHORT_CMD_LEN;
    end

    assign cidx_inc = {1'b0, cidx_reg} + 5'd1;
    assign fire     = res.valid && res.ready;

    // drive the current word and work out whether another one follows
    always_comb
    begin
        res.result_kind = scjr_pkg::KIND_TX;
        res.byte_value  = 8'h00;
        res.status_code = scjr_pkg::ST_NONE;
        more            = 1'b0;
        priority if (cur_reg.st_a != scjr_pkg::ST_NONE)
        begin
            res.result_kind = scjr_pkg::KIND_STATUS;
            res.status_code = cur_reg.st_a;
            more = (cur_reg.st_b != scjr_pkg::ST_NONE) || cur_reg.data_en ||
                   (cur_reg.cmd != scjr_pkg::CMD_NONE);
        end
        else if (cur_reg.st_b != scjr_pkg::ST_NONE)
        begin
            res.result_kind = scjr_pkg::KIND_STATUS;
            res.status_code = cur_reg.st_b;
            more = cur_reg.data_en || (cur_reg.cmd != scjr_pkg::CMD_NONE);
        end
        else if (cur_reg.data_en)
        begin
            res.result_kind = scjr_pkg::KIND_DATA;
            res.byte_value  = cur_reg.data;
            more = (cur_reg.cmd != scjr_pkg::CMD_NONE);
        end
        else
        begin
            res.result_kind = scjr_pkg::KIND_TX;
            res.byte_value  = cmd_byte;
            more = (cidx_inc < cmd_len);
        end
    end

    assign res.valid       = busy_reg;
    assign res.image_size  = cur_reg.size;
    assign res.byte_count  = cur_reg.count;
    assign res.last_of_run = !more;
    assign pop             = !empty && (!busy_reg || (fire && !more));

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg  <= head_job;
            cidx_reg <= 4'd0;
        end
        else if (fire)
        begin
            // retire the word just taken
            priority if (cur_reg.st_a != scjr_pkg::ST_NONE)
            begin
                cur_reg.st_a <= scjr_pkg::ST_NONE;
            end
            else if (cur_reg.st_b != scjr_pkg::ST_NONE)
            begin
                cur_reg.st_b <= scjr_pkg::ST_NONE;
            end
            else if (cur_reg.data_en)
            begin
                cur_reg.data_en <= 1'b0;
            end
            else
            begin
                cidx_reg <= cidx_inc[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
        end
        else if (fire && !more)
        begin
            busy_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && !res.last_of_run) |=> res.valid)
        else $error("result run broken before its last word");

    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.result_kind == scjr_pkg::KIND_STATUS) |->
        (res.byte_value == 8'h00 && res.status_code != scjr_pkg::ST_NONE))
        else $error("status word with byte or without code");

    a_code_only_status: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.result_kind != scjr_pkg::KIND_STATUS) |->
        res.status_code == scjr_pkg::ST_NONE)
        else $error("status code on a byte word");

    a_no_pop_midrun: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !(res.ready && res.last_of_run)) |-> !pop)
        else $error("job popped while a run is still going out");
`endif

endmodule

/* sv/serial_jpeg_camera_reader.sv */
// Serial JPEG camera reader, host side. Each request word (start, or one byte
// received from the camera) is taken while the four-entry job queue has
// room; the result words it causes (up to 17: a status and a 16-byte chunk
// read command) leave at one word per cycle from the back sequencer while
// the result port is ready, so the sustained rate is set by that port.
// Bytes received while idle cause nothing.
// Depends on scjr_pkg, scjr_ifs, scjr_front, scjr_queue, scjr_back.
module serial_jpeg_camera_reader #(
    parameter int CHUNK_BYTES = scjr_pkg::CHUNK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    scjr_req_if.sink    req,
    scjr_res_if.source  res
);

    logic           push;
    logic           full;
    logic           pop;
    logic           empty;
    scjr_pkg::job_t push_job;
    scjr_pkg::job_t head_job;

    scjr_front #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .full     (full),
        .push     (push),
        .push_job (push_job)
    );

    scjr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty)
    );

    scjr_back #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head_job (head_job),
        .pop      (pop),
        .res      (res)
    );

endmodule
